@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hw/rtl/dne_pkg.sv @@
// ----------------------------------------------------------------------------
// dne_pkg
// Shared widths, character codes and the result type of the number extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dne_pkg;

    localparam int VALUE_WIDTH = 32;
    // room for magnitude * 10 + digit
    localparam int PROD_WIDTH  = VALUE_WIDTH + 4;

    // largest magnitude kept: 2^(VALUE_WIDTH-1)
    localparam logic [PROD_WIDTH-1:0]  LIMIT_WIDE = PROD_WIDTH'(1) << (VALUE_WIDTH - 1);
    localparam logic [VALUE_WIDTH-1:0] LIMIT_MAG  = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);
    localparam logic [VALUE_WIDTH-1:0] MAX_POS    = LIMIT_MAG - VALUE_WIDTH'(1);

    // character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] number;
        logic                          has_number;
        logic                          saturated;
        logic                          text_done;
    } result_t;

endpackage

@@ hw/rtl/dne_core.sv @@
// ----------------------------------------------------------------------------
// dne_core
// Tokenizer state and the per-byte update; forms a result when a byte ends a run or the text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dne_core
    import dne_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       res_valid,
    output result_t    res
);

    logic                   in_digits_reg, in_digits_next;
    logic                   sign_pending_reg, sign_pending_next;
    logic                   sign_pending_minus_reg, sign_pending_minus_next;
    logic                   run_negative_reg, run_negative_next;
    logic [VALUE_WIDTH-1:0] magnitude_reg, magnitude_next;
    logic                   overflowed_reg, overflowed_next;

    logic                   is_nul;
    logic                   is_last;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [VALUE_WIDTH-1:0] base_mag;
    logic                   base_ovf;
    logic                   base_neg;
    logic [PROD_WIDTH-1:0]  prod;
    logic                   prod_over;
    logic [VALUE_WIDTH-1:0] run_mag;
    logic                   run_ovf;
    logic                   run_neg;
    logic                   run_active;
    result_t                run_res;

    // byte classification
    assign is_nul   = (text_byte == CHAR_NUL);
    assign is_last  = end_of_text | is_nul;
    assign is_digit = !is_nul && (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    assign digit    = 4'(text_byte - CHAR_ZERO);

    // a first digit starts a fresh run with the pending sign
    assign base_mag = in_digits_reg ? magnitude_reg : '0;
    assign base_ovf = in_digits_reg ? overflowed_reg : 1'b0;
    assign base_neg = in_digits_reg ? run_negative_reg
                                    : (sign_pending_reg & sign_pending_minus_reg);

    // magnitude * 10 + digit, overflow when above the limit
    assign prod      = (PROD_WIDTH'(base_mag) << 3) + (PROD_WIDTH'(base_mag) << 1)
                     + PROD_WIDTH'(digit);
    assign prod_over = (prod > LIMIT_WIDE);

    always_comb
    begin
        if (is_digit)
        begin
            run_neg = base_neg;
            run_ovf = base_ovf | prod_over;
            if (base_ovf)
                run_mag = base_mag;
            else if (prod_over)
                run_mag = LIMIT_MAG;
            else
                run_mag = prod[VALUE_WIDTH-1:0];
        end
        else
        begin
            run_neg = run_negative_reg;
            run_ovf = overflowed_reg;
            run_mag = magnitude_reg;
        end
    end

    assign run_active = in_digits_reg | is_digit;

    // signed value of the finished run, saturated when out of range
    always_comb
    begin
        run_res            = '0;
        run_res.has_number = 1'b1;
        if (run_neg)
        begin
            if (run_ovf)
            begin
                run_res.number    = LIMIT_MAG;
                run_res.saturated = 1'b1;
            end
            else
                run_res.number = -run_mag;
        end
        else
        begin
            if (run_ovf || run_mag[VALUE_WIDTH-1])
            begin
                run_res.number    = MAX_POS;
                run_res.saturated = 1'b1;
            end
            else
                run_res.number = run_mag;
        end
    end

    // next state and result of the byte
    always_comb
    begin
        in_digits_next          = in_digits_reg;
        sign_pending_next       = sign_pending_reg;
        sign_pending_minus_next = sign_pending_minus_reg;
        run_negative_next       = run_negative_reg;
        magnitude_next          = magnitude_reg;
        overflowed_next         = overflowed_reg;
        res_valid               = 1'b0;
        res                     = '0;

        if (step_en)
        begin
            if (is_last)
            begin
                res_valid = 1'b1;
                if (run_active)
                    res = run_res;
                res.text_done           = 1'b1;
                in_digits_next          = 1'b0;
                sign_pending_next       = 1'b0;
                sign_pending_minus_next = 1'b0;
                run_negative_next       = 1'b0;
                magnitude_next          = '0;
                overflowed_next         = 1'b0;
            end
            else if (is_digit)
            begin
                in_digits_next          = 1'b1;
                sign_pending_next       = 1'b0;
                sign_pending_minus_next = 1'b0;
                run_negative_next       = run_neg;
                magnitude_next          = run_mag;
                overflowed_next         = run_ovf;
            end
            else
            begin
                // other byte: close any run, track a sign byte
                res_valid          = in_digits_reg;
                res                = run_res;
                res.text_done      = 1'b0;
                in_digits_next     = 1'b0;
                run_negative_next  = 1'b0;
                magnitude_next     = '0;
                overflowed_next    = 1'b0;
                sign_pending_next  = (text_byte == CHAR_PLUS) || (text_byte == CHAR_MINUS);
                sign_pending_minus_next = (text_byte == CHAR_MINUS);
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_digits_reg          <= 1'b0;
            sign_pending_reg       <= 1'b0;
            sign_pending_minus_reg <= 1'b0;
            run_negative_reg       <= 1'b0;
            magnitude_reg          <= '0;
            overflowed_reg         <= 1'b0;
        end
        else
        begin
            in_digits_reg          <= in_digits_next;
            sign_pending_reg       <= sign_pending_next;
            sign_pending_minus_reg <= sign_pending_minus_next;
            run_negative_reg       <= run_negative_next;
            magnitude_reg          <= magnitude_next;
            overflowed_reg         <= overflowed_next;
        end
    end

endmodule

@@ hw/rtl/decimal_number_extractor_top.sv @@
// Results are registered in the output register, or the skid entry when it stalls.
// Throughput: one byte per cycle while in_stall is low; the limit is the
// combinational magnitude update (times ten, add digit, range compare) in dne_core.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset (rst_n low, asynchronous) clears the tokenizer state and empties the buffer.
// ----------------------------------------------------------------------------
// decimal_number_extractor_top
// Extracts signed decimal integers from bytes, one result per number or text end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module decimal_number_extractor_top
    import dne_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    text_byte,
    input  logic                          end_of_text,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] number,
    output logic                          has_number,
    output logic                          saturated,
    output logic                          text_done
);

    logic    step_en;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign in_stall = skid_valid_reg;
    assign step_en  = in_valid & ~in_stall;
    assign pop      = out_valid_reg & ~out_stall;

    dne_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .res_valid   (res_valid),
        .res         (res)
    );

    // output register plus skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                main_next      = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    // buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // buffer payload
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid  = out_valid_reg;
    assign number     = main_reg.number;
    assign has_number = main_reg.has_number;
    assign saturated  = main_reg.saturated;
    assign text_done  = main_reg.text_done;

    // buffer and result consistency
    `ASSERT_IMPLIES(a_skid_needs_main, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry held while output register is empty")
    `ASSERT_NEXT(a_skid_moves_up, clk, rst_n, skid_valid_reg && !out_stall,
        out_valid_reg && !skid_valid_reg, "skid entry not moved to output register")
    `ASSERT_IMPLIES(a_sat_has_number, clk, rst_n, out_valid_reg && saturated, has_number,
        "saturated transaction without a number")
    `ASSERT_IMPLIES(a_empty_closes_text, clk, rst_n, out_valid_reg && !has_number,
        text_done && (number == '0) && !saturated, "empty transaction not closing the text")

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for decimal_number_extractor_top. Byte streams of
// well-formed texts, boundary numbers and raw noise are sent through the
// valid/stall input. A scoreboard predicts each extracted number and checks
// every output transaction in order, under several sender and receiver
// idling patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import dne_pkg::*;

    localparam int          IDLE_LIMIT  = 5000;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [63:0] LIMIT64     = 64'd1 << (VALUE_WIDTH - 1);
    localparam logic [7:0]  CHAR_SPACE  = 8'h20;
    localparam logic [7:0]  CHAR_COMMA  = 8'h2C;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic [7:0]                    text_byte   = 8'h00;
    logic                          end_of_text = 1'b0;
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic signed [VALUE_WIDTH-1:0] number;
    logic                          has_number;
    logic                          saturated;
    logic                          text_done;

    // tokenizer state of the predictor
    logic        in_run;
    logic        sign_seen;
    logic        sign_minus;
    logic        run_neg;
    logic [63:0] run_mag;
    logic        run_ovf;

    result_t     expected_results[$];
    logic [7:0]  text_buf[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic holding      = 1'b0;
    event hold_off_ev;

    int error_count     = 0;
    int bytes_sent      = 0;
    int results_checked = 0;
    int numbers_seen    = 0;
    int saturated_seen  = 0;
    int texts_closed    = 0;
    int idle_cycles     = 0;

    decimal_number_extractor_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .number      (number),
        .has_number  (has_number),
        .saturated   (saturated),
        .text_done   (text_done)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_tokenizer();
        in_run     = 1'b0;
        sign_seen  = 1'b0;
        sign_minus = 1'b0;
        run_neg    = 1'b0;
        run_mag    = '0;
        run_ovf    = 1'b0;
    endfunction

    // signed value of the finished run, saturated at the range limits
    function automatic result_t finished_run(logic done);
        result_t r;
        r.has_number = 1'b1;
        r.text_done  = done;
        r.saturated  = 1'b0;
        if (run_neg)
        begin
            if (run_ovf)
            begin
                r.number    = LIMIT_MAG;
                r.saturated = 1'b1;
            end
            else
            begin
                r.number = VALUE_WIDTH'(64'd0 - run_mag);
            end
        end
        else if (run_ovf || run_mag >= LIMIT64)
        begin
            r.number    = MAX_POS;
            r.saturated = 1'b1;
        end
        else
        begin
            r.number = VALUE_WIDTH'(run_mag);
        end
        return r;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eot);
        logic       last;
        logic       is_digit;
        logic [3:0] d;
        result_t    r;
        last     = eot;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        if (b == CHAR_NUL)
        begin
            last     = 1'b1;
            is_digit = 1'b0;
        end
        else if (is_digit)
        begin
            // first digit takes the pending sign
            if (!in_run)
            begin
                in_run     = 1'b1;
                run_neg    = sign_seen && sign_minus;
                sign_seen  = 1'b0;
                sign_minus = 1'b0;
                run_mag    = '0;
                run_ovf    = 1'b0;
            end
            d = 4'(b - CHAR_ZERO);
            if (!run_ovf)
            begin
                if (run_mag > (LIMIT64 - 64'(d)) / 64'd10)
                begin
                    run_ovf = 1'b1;
                    run_mag = LIMIT64;
                end
                else
                begin
                    run_mag = run_mag * 64'd10 + 64'(d);
                end
            end
            if (!last)
                return;
        end

        // end of text flushes the run or reports an empty close
        if (last)
        begin
            if (in_run)
            begin
                expected_results.push_back(finished_run(1'b1));
            end
            else
            begin
                r           = '0;
                r.text_done = 1'b1;
                expected_results.push_back(r);
            end
            clear_tokenizer();
            return;
        end

        // separator ends the run and may leave a sign pending
        if (in_run)
            expected_results.push_back(finished_run(1'b0));
        in_run     = 1'b0;
        run_neg    = 1'b0;
        run_mag    = '0;
        run_ovf    = 1'b0;
        sign_seen  = (b == CHAR_PLUS) || (b == CHAR_MINUS);
        sign_minus = (b == CHAR_MINUS);
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    task automatic send_byte(logic [7:0] b, logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b, eot);
        bytes_sent++;
    endtask

    task automatic send_string(string s, logic eot_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_last && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // any byte that is neither a digit nor zero
    function automatic logic [7:0] pick_separator();
        case ($urandom_range(7))
            0:       return CHAR_SPACE;
            1:       return CHAR_COMMA;
            2:       return CHAR_PLUS;
            3:       return CHAR_MINUS;
            4:       return 8'($urandom_range(8'h61, 8'h7A));
            5:       return 8'($urandom_range(8'h80, 8'hFF));
            6:       return 8'($urandom_range(8'h01, 8'h2F));
            default: return 8'($urandom_range(8'h3A, 8'h7F));
        endcase
    endfunction

    function automatic void push_digits(int count);
        repeat (count)
            text_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
    endfunction

    // optional sign, then a digit run biased toward the range limits
    function automatic void push_number();
        string near_limit;
        near_limit = "214748364";
        case ($urandom_range(3))
            1:       text_buf.push_back(CHAR_PLUS);
            2:       text_buf.push_back(CHAR_MINUS);
            default: ;
        endcase
        case ($urandom_range(9))
            0:
            begin
                for (int i = 0; i < near_limit.len(); i++)
                    text_buf.push_back(near_limit[i]);
                text_buf.push_back(CHAR_ZERO + 8'($urandom_range(6, 9)));
            end
            1: push_digits($urandom_range(11, 20));
            2:
            begin
                repeat ($urandom_range(1, 3))
                    text_buf.push_back(CHAR_ZERO);
                push_digits($urandom_range(1, 10));
            end
            default: push_digits($urandom_range(1, $urandom_range(1, 10)));
        endcase
    endfunction

    task automatic send_well_formed_text();
        int ending;
        text_buf.delete();
        for (int k = 0; k < $urandom_range(1, 5); k++)
        begin
            if (k > 0 || $urandom_range(1))
                repeat ($urandom_range(1, 2))
                    text_buf.push_back(pick_separator());
            push_number();
        end
        ending = $urandom_range(3);
        if (ending == 1)
            text_buf.push_back(pick_separator());
        else if (ending >= 2)
            text_buf.push_back(CHAR_NUL);
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], (ending != 2) && (i == text_buf.size() - 1));
    endtask

    task automatic send_noise(int count);
        repeat (count)
            send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
    endtask

    task automatic send_random_texts(int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
                send_noise($urandom_range(1, 12));
            else
                send_well_formed_text();
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------

    // random stall, forced high during a hold-off
    always @(posedge clk)
        out_stall <= holding || ($urandom_range(99) < recv_stall_pct);

    // long hold-off, counted here
    initial
    begin
        forever
        begin
            @(hold_off_ev);
            @(posedge clk);
            holding <= 1'b1;
            repeat (HOLD_CYCLES)
                @(posedge clk);
            holding <= 1'b0;
        end
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: number %0d has_number %0b text_done %0b",
                       number, has_number, text_done);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (number !== want.number)
                begin
                    $error("number: expected %0d, got %0d", want.number, number);
                    error_count++;
                end
                if (has_number !== want.has_number)
                begin
                    $error("has_number: expected %0b, got %0b", want.has_number, has_number);
                    error_count++;
                end
                if (saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b", want.saturated, saturated);
                    error_count++;
                end
                if (text_done !== want.text_done)
                begin
                    $error("text_done: expected %0b, got %0b", want.text_done, text_done);
                    error_count++;
                end
                results_checked++;
                if (want.has_number)
                    numbers_seen++;
                if (want.saturated)
                    saturated_seen++;
                if (want.text_done)
                    texts_closed++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $error("no transaction for %0d cycles, %0d results outstanding",
                       idle_cycles, expected_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // digit on the last byte with a plus sign
        send_string("+7", 1'b1);
        // sign without digits, then zero byte with nothing pending
        send_string("-x", 1'b0);
        send_byte(CHAR_NUL, 1'b0);
        // zero byte carrying the end flag flushes the run
        send_string("9", 1'b0);
        send_byte(CHAR_NUL, 1'b1);
        // end on a non-digit with nothing pending
        send_byte(8'hFF, 1'b1);
        // negative run past the range saturates to the minimum
        send_string("-2147483649", 1'b1);
        // later sign replaces the pending one
        send_string("-+3 ", 1'b0);
        send_byte(CHAR_NUL, 1'b1);
    endtask

    task automatic test_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_texts(320);
    endtask

    task automatic test_sender_idle();
        send_idle_pct  = 45;
        recv_stall_pct = 0;
        send_random_texts(320);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        send_random_texts(320);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        send_random_texts(320);
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_off_ev;
        send_random_texts(150);
    endtask

    // sender pauses until the output is drained, then resumes
    task automatic test_pause();
        send_idle_pct  = 10;
        recv_stall_pct = 20;
        send_random_texts(30);
        wait_drained();
        send_random_texts(30);
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        clear_tokenizer();
        @(posedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_hold_off();
        test_pause();

        wait_drained();
        repeat (8)
            @(posedge clk);

        $display("sent %0d bytes, checked %0d results: %0d numbers, %0d saturated, %0d texts",
                 bytes_sent, results_checked, numbers_seen, saturated_seen, texts_closed);
        $display("phases: no idling, sender gaps, receiver stalls, both, hold-off, drain pause");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
